[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/itp_pkg.sv]
`timescale 1ns / 1ps

package itp_pkg;

	localparam int CHAR_W = 8;
	localparam int ERR_W  = 2;
	localparam int RANK_W = 2;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [ERR_W-1:0]  err_t;
	typedef logic [RANK_W-1:0] rank_t;

	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_MUL    = 8'h2a;
	localparam char_t CH_ADD    = 8'h2b;
	localparam char_t CH_SUB    = 8'h2d;
	localparam char_t CH_DIV    = 8'h2f;
	localparam char_t CH_POW    = 8'h5e;
	localparam char_t CH_NUL    = 8'h00;

	localparam err_t ERR_NONE      = 2'd0;
	localparam err_t ERR_OVERFLOW  = 2'd1;
	localparam err_t ERR_UNMATCHED = 2'd2;

	localparam rank_t RANK_NONE = 2'd0;
	localparam rank_t RANK_ADD  = 2'd1;
	localparam rank_t RANK_MUL  = 2'd2;
	localparam rank_t RANK_POW  = 2'd3;

	// operator priority; parentheses and operands rank zero
	function automatic rank_t rank_of(input char_t c);
		rank_t r;
		unique case (c) inside
			CH_POW:         r = RANK_POW;
			CH_MUL, CH_DIV: r = RANK_MUL;
			CH_ADD, CH_SUB: r = RANK_ADD;
			default:        r = RANK_NONE;
		endcase
		return r;
	endfunction

endpackage

[rtl/itp_in_if.sv]
`timescale 1ns / 1ps

interface itp_in_if;
	import itp_pkg::*;

	logic  valid;
	logic  ready;
	char_t char_code;
	logic  end_of_expression;

	modport source (output valid, output char_code, output end_of_expression, input ready);
	modport sink (input valid, input char_code, input end_of_expression, output ready);
endinterface

[rtl/itp_out_if.sv]
`timescale 1ns / 1ps

interface itp_out_if;
	import itp_pkg::*;

	logic  valid;
	logic  ready;
	char_t symbol;
	err_t  error_code;
	logic  last_of_run;

	modport source (output valid, output symbol, output error_code, output last_of_run,
		input ready);
	modport sink (input valid, input symbol, input error_code, input last_of_run,
		output ready);
endinterface

[rtl/infix_to_postfix_converter_top.sv]
`timescale 1ns / 1ps

// Infix to postfix converter (shunting-yard) with an operator stack in RAM.
// expr: one character per beat, end_of_expression marks the last character
// of an expression, after which the stack is emptied to the output.
// postfix: zero or more result beats per input beat; last_of_run flags the
// final result of each input beat. error_code 1 reports a push onto a full
// stack (symbol 0), 2 reports a ')' with no '(' (symbol 0).
// One input beat at a time: expr.ready is high only while idle. A beat is
// decoded in ST_DECIDE, each stack entry inspected takes ST_READ then ST_CHECK,
// a popping loop that finds the stack empty ends in ST_READ, and ST_FINISH
// closes the run; e.g. an operand takes ST_DECIDE and ST_FINISH, an operator on
// an empty stack adds ST_READ, one that pops nothing from a non-empty stack adds
// ST_READ and ST_CHECK. The stack RAM has one registered read port, so each stack
// entry examined costs a read state (ST_READ) plus a decision state (ST_CHECK).
// Results pass through a one-deep hold and an output register; while the
// receiver holds postfix.ready low the sequencer stalls once both are full.
// Reset (arst_n low) empties the stack, drops any pending result and returns
// to idle; no clearing pass is needed since only live entries are read.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	itp_in_if.sink    expr,
	itp_out_if.source postfix
);
	import itp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MD_CLOSE,
		MD_OPER,
		MD_FLUSH
	} mode_t;

	state_t        state_q, nxt_state;
	mode_t         mode_q, nxt_mode;
	char_t         char_q;
	logic          last_q;
	logic [CW-1:0] cnt_q;
	logic          pend_v_q;
	char_t         pend_sym_q;
	err_t          pend_err_q;
	logic          out_v_q;
	char_t         out_sym_q;
	err_t          out_err_q;
	logic          out_last_q;

	logic          stall;
	logic          emit;
	char_t         emit_sym;
	err_t          emit_err;
	logic          push;
	logic          pop;
	logic          fin;
	logic          go_after;
	logic          full;
	logic          load_out;
	logic [CW-1:0] top_idx;
	char_t         top_char;

	assign full    = (cnt_q == CNT_FULL);
	assign top_idx = cnt_q - CNT_ONE;

	itp_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(char_q),
		.rd_addr(top_idx[AW-1:0]),
		.rd_data(top_char)
	);

	// hold stage can only move on when the output register is free
	assign stall = pend_v_q && out_v_q && !postfix.ready;

	always_comb begin
		nxt_state = state_q;
		nxt_mode  = mode_q;
		emit      = 1'b0;
		emit_sym  = char_q;
		emit_err  = ERR_NONE;
		push      = 1'b0;
		pop       = 1'b0;
		fin       = 1'b0;
		go_after  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (expr.valid) begin
					nxt_state = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!stall) begin
					if (char_q == CH_LPAREN) begin
						if (full) begin
							emit     = 1'b1;
							emit_sym = CH_NUL;
							emit_err = ERR_OVERFLOW;
						end else begin
							push = 1'b1;
						end
						go_after = 1'b1;
					end else if (char_q == CH_RPAREN) begin
						nxt_mode  = MD_CLOSE;
						nxt_state = ST_READ;
					end else if (rank_of(char_q) != RANK_NONE) begin
						nxt_mode  = MD_OPER;
						nxt_state = ST_READ;
					end else begin
						emit     = 1'b1;
						go_after = 1'b1;
					end
				end
			end
			ST_READ: begin
				if (!stall) begin
					if (cnt_q == '0) begin
						unique case (mode_q)
							MD_CLOSE: begin
								emit     = 1'b1;
								emit_sym = CH_NUL;
								emit_err = ERR_UNMATCHED;
								go_after = 1'b1;
							end
							MD_OPER: begin
								push     = 1'b1;
								go_after = 1'b1;
							end
							MD_FLUSH: nxt_state = ST_FINISH;
							default:  nxt_state = ST_FINISH;
						endcase
					end else begin
						nxt_state = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (!stall) begin
					unique case (mode_q)
						MD_CLOSE: begin
							pop = 1'b1;
							if (top_char == CH_LPAREN) begin
								go_after = 1'b1;
							end else begin
								emit      = 1'b1;
								emit_sym  = top_char;
								nxt_state = ST_READ;
							end
						end
						MD_OPER: begin
							if (rank_of(char_q) <= rank_of(top_char)) begin
								pop       = 1'b1;
								emit      = 1'b1;
								emit_sym  = top_char;
								nxt_state = ST_READ;
							end else begin
								if (full) begin
									emit     = 1'b1;
									emit_sym = CH_NUL;
									emit_err = ERR_OVERFLOW;
								end else begin
									push = 1'b1;
								end
								go_after = 1'b1;
							end
						end
						MD_FLUSH: begin
							pop       = 1'b1;
							emit      = 1'b1;
							emit_sym  = top_char;
							nxt_state = ST_READ;
						end
						default: nxt_state = ST_FINISH;
					endcase
				end
			end
			ST_FINISH: begin
				if (!stall) begin
					fin       = 1'b1;
					nxt_state = ST_IDLE;
				end
			end
			default: nxt_state = ST_IDLE;
		endcase
		// end of the item's own work: empty the stack if it closes an expression
		if (go_after) begin
			if (last_q) begin
				nxt_mode  = MD_FLUSH;
				nxt_state = ST_READ;
			end else begin
				nxt_state = ST_FINISH;
			end
		end
	end

	assign load_out = pend_v_q && (emit || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MD_FLUSH;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= nxt_state;
			mode_q  <= nxt_mode;
			if (state_q == ST_IDLE && expr.valid) begin
				char_q <= expr.char_code;
				last_q <= expr.end_of_expression;
			end
			if (push) begin
				cnt_q <= cnt_q + CNT_ONE;
			end else if (pop) begin
				cnt_q <= cnt_q - CNT_ONE;
			end
			if (fin) begin
				pend_v_q <= 1'b0;
			end else if (emit) begin
				pend_v_q   <= 1'b1;
				pend_sym_q <= emit_sym;
				pend_err_q <= emit_err;
			end
			if (load_out) begin
				out_v_q    <= 1'b1;
				out_sym_q  <= pend_sym_q;
				out_err_q  <= pend_err_q;
				out_last_q <= fin;
			end else if (postfix.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign expr.ready          = (state_q == ST_IDLE);
	assign postfix.valid       = out_v_q;
	assign postfix.symbol      = out_sym_q;
	assign postfix.error_code  = out_err_q;
	assign postfix.last_of_run = out_last_q;
endmodule

[rtl/itp_ram.sv]
`timescale 1ns / 1ps

module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

[rtl/itp_checker.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module itp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 expr_valid,
	input logic                 expr_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input itp_pkg::char_t       out_symbol,
	input itp_pkg::err_t        out_error_code,
	input logic                 out_last
);
	import itp_pkg::*;

	// one character in flight: the block is busy the cycle after a beat
	`ASSERT_NEXT(a_busy_after_beat, expr_valid && expr_ready, !expr_ready, "ready after accept")

	// error results carry a null symbol
	`ASSERT_SAME(a_error_null, out_valid && out_error_code != ERR_NONE,
		out_symbol == CH_NUL, "error result with symbol")

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")

	`ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(out_symbol) && $stable(out_error_code) && $stable(out_last),
		"result changed under stall")
endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.expr_valid    (expr.valid),
	.expr_ready    (expr.ready),
	.out_valid     (postfix.valid),
	.out_ready     (postfix.ready),
	.out_symbol    (postfix.symbol),
	.out_error_code(postfix.error_code),
	.out_last      (postfix.last_of_run)
);

[tb/itp_postfix_checker.sv]
`timescale 1ns / 1ps

module itp_postfix_checker #(
	parameter int STACK_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	itp_in_if   expr,
	itp_out_if  postfix,
	output int  mismatch_count,
	output int  postfix_owed
);
	import itp_pkg::*;

	localparam int MAX_PRINTED = 30;

	typedef struct packed {
		char_t symbol;
		err_t  error_code;
		logic  last_of_run;
	} postfix_beat_t;

	postfix_beat_t postfix_due[$];
	char_t         op_stack [STACK_DEPTH];
	int            stack_used;

	function automatic rank_t precedence(input char_t c);
		if (c == CH_POW)
			return RANK_POW;
		if (c == CH_MUL || c == CH_DIV)
			return RANK_MUL;
		if (c == CH_ADD || c == CH_SUB)
			return RANK_ADD;
		return RANK_NONE;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatch_count < MAX_PRINTED)
			$display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	task automatic emit_beat(input char_t sym, input err_t err);
		postfix_beat_t b;
		b.symbol      = sym;
		b.error_code  = err;
		b.last_of_run = 1'b0;
		postfix_due.push_back(b);
	endtask

	task automatic push_operator(input char_t c);
		if (stack_used >= STACK_DEPTH) begin
			emit_beat(CH_NUL, ERR_OVERFLOW);
		end else begin
			op_stack[stack_used] = c;
			stack_used++;
		end
	endtask

	// expected postfix beats for one input character
	task automatic translate_char(input char_t c, input logic final_char);
		int    first;
		logic  matched;
		rank_t r;
		first   = postfix_due.size();
		matched = 1'b0;
		r       = precedence(c);
		if (c == CH_LPAREN) begin
			push_operator(c);
		end else if (c == CH_RPAREN) begin
			while (stack_used > 0 && !matched) begin
				stack_used--;
				if (op_stack[stack_used] == CH_LPAREN)
					matched = 1'b1;
				else
					emit_beat(op_stack[stack_used], ERR_NONE);
			end
			if (!matched)
				emit_beat(CH_NUL, ERR_UNMATCHED);
		end else if (r != RANK_NONE) begin
			// left-associative: equal priority pops too, '(' ranks zero so it stops the loop
			while (stack_used > 0 && r <= precedence(op_stack[stack_used-1])) begin
				stack_used--;
				emit_beat(op_stack[stack_used], ERR_NONE);
			end
			push_operator(c);
		end else begin
			emit_beat(c, ERR_NONE);
		end
		if (final_char) begin
			while (stack_used > 0) begin
				stack_used--;
				emit_beat(op_stack[stack_used], ERR_NONE);
			end
		end
		if (postfix_due.size() > first)
			postfix_due[postfix_due.size()-1].last_of_run = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		postfix_beat_t seen;
		postfix_beat_t want;
		if (!arst_n) begin
			stack_used     = 0;
			mismatch_count = 0;
			postfix_due.delete();
			postfix_owed <= 0;
		end else begin
			if (expr.valid && expr.ready)
				translate_char(expr.char_code, expr.end_of_expression);
			if (postfix.valid && postfix.ready) begin
				seen.symbol      = postfix.symbol;
				seen.error_code  = postfix.error_code;
				seen.last_of_run = postfix.last_of_run;
				if (postfix_due.size() == 0) begin
					flag_mismatch("result beat with nothing due", int'(seen), 0);
				end else begin
					want = postfix_due.pop_front();
					if (seen.symbol !== want.symbol)
						flag_mismatch("symbol", int'(seen.symbol), int'(want.symbol));
					if (seen.error_code !== want.error_code)
						flag_mismatch("error_code", int'(seen.error_code),
							int'(want.error_code));
					if (seen.last_of_run !== want.last_of_run)
						flag_mismatch("last_of_run", int'(seen.last_of_run),
							int'(want.last_of_run));
				end
			end
			postfix_owed <= postfix_due.size();
		end
	end

endmodule

[tb/infix_to_postfix_converter_top_tb.sv]
`timescale 1ns / 1ps

module infix_to_postfix_converter_top_tb;
	import itp_pkg::*;

	localparam int STACK_DEPTH     = 32;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 100;
	localparam int ITEMS_PER_PHASE = 45;

	typedef struct {
		char_t code;
		logic  last;
	} script_beat_t;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   postfix_owed;
	int   rx_idle_pct;
	int   hold_req;
	int   send_idle_pct;
	int   chars_sent;

	script_beat_t script[$];

	itp_in_if  expr();
	itp_out_if postfix();

	infix_to_postfix_converter_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr),
		.postfix(postfix)
	);

	itp_postfix_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) postfix_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.expr          (expr),
		.postfix       (postfix),
		.mismatch_count(mismatch_count),
		.postfix_owed  (postfix_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		int stall_left;
		int hold_seen;
		stall_left   = 0;
		hold_seen    = 0;
		postfix.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen  = hold_req;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				postfix.ready <= 1'b0;
			end else begin
				postfix.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic char_t pick_operand();
		char_t c;
		do
			c = char_t'($urandom_range(0, 255));
		while (c == CH_LPAREN || c == CH_RPAREN || c == CH_ADD || c == CH_SUB ||
			c == CH_MUL || c == CH_DIV || c == CH_POW);
		return c;
	endfunction

	function automatic char_t pick_operator();
		case ($urandom_range(0, 4))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			3: return CH_DIV;
			default: return CH_POW;
		endcase
	endfunction

	task automatic append_beat(input char_t c, input logic last);
		script_beat_t b;
		b.code = c;
		b.last = last;
		script.push_back(b);
	endtask

	// balanced expression, last beat flagged
	task automatic build_formula();
		int terms;
		int open;
		terms = $urandom_range(1, 8);
		open  = 0;
		for (int i = 0; i < terms; i++) begin
			while (open < 6 && $urandom_range(0, 3) == 0) begin
				append_beat(CH_LPAREN, 1'b0);
				open++;
			end
			append_beat(pick_operand(), 1'b0);
			while (open > 0 && $urandom_range(0, 2) == 0) begin
				append_beat(CH_RPAREN, 1'b0);
				open--;
			end
			if (i < terms - 1)
				append_beat(pick_operator(), 1'b0);
		end
		while (open > 0) begin
			append_beat(CH_RPAREN, 1'b0);
			open--;
		end
		script[script.size()-1].last = 1'b1;
	endtask

	// every push lands on '(' so none pops; more pushes than depth overflow
	task automatic build_deep_nest(input int pushes);
		logic after_open;
		after_open = 1'b0;
		for (int i = 0; i < pushes; i++) begin
			if (after_open && $urandom_range(0, 3) == 0) begin
				append_beat(pick_operand(), 1'b0);
				append_beat(pick_operator(), 1'b0);
				after_open = 1'b0;
			end else begin
				append_beat(CH_LPAREN, 1'b0);
				after_open = 1'b1;
			end
		end
		append_beat(pick_operand(), 1'b1);
	endtask

	task automatic build_random_line();
		int kind;
		int idx;
		kind = $urandom_range(0, 15);
		if (kind == 0) begin
			build_deep_nest($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2));
		end else if (kind <= 2) begin
			repeat ($urandom_range(1, 6))
				append_beat(char_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			script[script.size()-1].last = 1'b1;
		end else if (kind <= 5) begin
			build_formula();
			repeat ($urandom_range(1, 2)) begin
				idx = $urandom_range(0, script.size() - 1);
				case ($urandom_range(0, 3))
					0: script[idx].code = CH_LPAREN;
					1: script[idx].code = CH_RPAREN;
					2: script[idx].code = pick_operator();
					default: script[idx].code = char_t'($urandom_range(0, 255));
				endcase
			end
			// sometimes leave the stack loaded for the next expression
			if ($urandom_range(0, 2) == 0)
				script[script.size()-1].last = 1'b0;
		end else begin
			build_formula();
		end
	endtask

	task automatic send_char(input char_t c, input logic last);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			expr.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		expr.valid             <= 1'b1;
		expr.char_code         <= c;
		expr.end_of_expression <= last;
		do
			@(posedge clk);
		while (!expr.ready);
		chars_sent++;
	endtask

	task automatic send_script();
		foreach (script[i])
			send_char(script[i].code, script[i].last);
		script.delete();
	endtask

	task automatic wait_for_results();
		expr.valid <= 1'b0;
		do
			@(posedge clk);
		while (postfix_owed != 0);
	endtask

	initial begin
		int target;
		arst_n                 = 1'b0;
		expr.valid             = 1'b0;
		expr.char_code         = CH_NUL;
		expr.end_of_expression = 1'b0;
		rx_idle_pct            = 50;
		hold_req               = 0;
		send_idle_pct          = 0;
		chars_sent             = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// operand extremes, then ')' on an empty stack
		append_beat(CH_NUL, 1'b0);
		append_beat(8'hff, 1'b1);
		append_beat(CH_RPAREN, 1'b0);
		// every operator, with pops on equal and higher priority
		append_beat(pick_operand(), 1'b0);
		append_beat(CH_ADD, 1'b0);
		append_beat(pick_operand(), 1'b0);
		append_beat(CH_MUL, 1'b0);
		append_beat(pick_operand(), 1'b0);
		append_beat(CH_POW, 1'b0);
		append_beat(pick_operand(), 1'b0);
		append_beat(CH_SUB, 1'b0);
		append_beat(pick_operand(), 1'b0);
		append_beat(CH_DIV, 1'b0);
		append_beat(pick_operand(), 1'b1);
		// operator stops at '(', then an unmatched '(' flushed at the end
		append_beat(CH_LPAREN, 1'b0);
		append_beat(pick_operand(), 1'b0);
		append_beat(CH_ADD, 1'b0);
		append_beat(pick_operand(), 1'b0);
		append_beat(CH_RPAREN, 1'b0);
		append_beat(CH_LPAREN, 1'b1);
		append_beat(CH_POW, 1'b0);
		append_beat(CH_POW, 1'b0);
		append_beat(pick_operand(), 1'b1);
		append_beat(CH_RPAREN, 1'b1);
		send_script();
		wait_for_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 25;
					rx_idle_pct   = 81;
				end
				1: begin
					send_idle_pct = 81;
					rx_idle_pct   = 25;
				end
				default: begin
					send_idle_pct = 0;
					rx_idle_pct   = 0;
				end
			endcase
			if (phase == 2) begin
				// receiver holds off while the sender keeps offering, overflow included
				hold_req = hold_req + 1;
				build_deep_nest(STACK_DEPTH + 2);
				send_script();
				build_formula();
				send_script();
				wait_for_results();
			end
			target = chars_sent + ITEMS_PER_PHASE;
			while (chars_sent < target) begin
				build_random_line();
				send_script();
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && postfix_owed == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
